// ===== rtl/core/chain_code_line_plotter_core_assert.svh =====
// Assertion macros for the chain code plotter.
// Each macro expands to one labeled concurrent assertion, clocked on clk and
// disabled while rst_n is low.
`ifndef CHAIN_CODE_LINE_PLOTTER_CORE_ASSERT_SVH
`define CHAIN_CODE_LINE_PLOTTER_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CCLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define CCLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cclp_pkg.sv =====
`timescale 1ns / 1ps

package cclp_pkg;

    // Grid geometry
    localparam int GRID_SIZE = 128;
    localparam int COORD_W   = $clog2(GRID_SIZE);
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Port field widths
    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int FIELD_W  = 7;
    localparam int MARK_W   = 3;

    localparam logic [COORD_W-1:0] CENTER   = COORD_W'(GRID_SIZE / 2);
    localparam logic [COORD_W-1:0] EDGE_MAX = COORD_W'(GRID_SIZE - 1);
    localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CODE = 2'd0,
        ACT_NEW  = 2'd1,
        ACT_READ = 2'd2
    } act_t;

    typedef enum logic [MARK_W-1:0] {
        MARK_BLANK = 3'd0,
        MARK_DASH  = 3'd1,
        MARK_SLASH = 3'd2,
        MARK_BAR   = 3'd3,
        MARK_BACK  = 3'd4
    } mark_t;

    typedef enum logic [1:0] {
        STEP_HOLD,
        STEP_INC,
        STEP_DEC
    } step_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ
    } state_t;

    // Column step by direction: east is increasing column
    function automatic step_t col_step(input logic [2:0] dir);
        step_t s;
        unique case (dir)
            3'd0, 3'd1, 3'd7: s = STEP_INC;
            3'd3, 3'd4, 3'd5: s = STEP_DEC;
            default:          s = STEP_HOLD;
        endcase
        return s;
    endfunction

    // Row step by direction: rows grow downward, north decreases row
    function automatic step_t row_step(input logic [2:0] dir);
        step_t s;
        unique case (dir)
            3'd1, 3'd2, 3'd3: s = STEP_DEC;
            3'd5, 3'd6, 3'd7: s = STEP_INC;
            default:          s = STEP_HOLD;
        endcase
        return s;
    endfunction

    function automatic mark_t dir_mark(input logic [2:0] dir);
        mark_t m;
        unique case (dir[1:0])
            2'd0:    m = MARK_DASH;
            2'd1:    m = MARK_SLASH;
            2'd2:    m = MARK_BAR;
            default: m = MARK_BACK;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/chain_code_line_plotter_core.sv =====
// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid, cmd_stall | action, code_byte, read_col, read_row
// res     | out       | res_valid, res_stall | pen_col, pen_row, box_*, cell_mark, off_grid
//
// Code byte and new-path requests give their result in the cycle after acceptance; a read
// request goes through the registered read port and ST_READ, holding cmd_stall high there.
// Reset and each new-path request run a clearing pass that writes one memory entry a
// cycle across all 2**(2*COORD_W) entries (16384 on a 128 x 128 grid), with cmd_stall high.
// One request is in flight at a time; a result still waiting on res_stall holds
// cmd_stall high, so the next request is accepted only once that result is taken.
`timescale 1ns / 1ps

module chain_code_line_plotter_core
    import cclp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [BYTE_W-1:0]   code_byte,
    input  logic [FIELD_W-1:0]  read_col,
    input  logic [FIELD_W-1:0]  read_row,

    output logic                res_valid,
    input  logic                res_stall,
    output logic [FIELD_W-1:0]  pen_col,
    output logic [FIELD_W-1:0]  pen_row,
    output logic [FIELD_W-1:0]  box_col_low,
    output logic [FIELD_W-1:0]  box_col_high,
    output logic [FIELD_W-1:0]  box_row_low,
    output logic [FIELD_W-1:0]  box_row_high,
    output logic [MARK_W-1:0]   cell_mark,
    output logic                off_grid
);

    // ------------------------------------------------------------------
    // Control and pen state
    // ------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic                 rd_in_grid_reg, rd_in_grid_next;

    logic [COORD_W-1:0]   pen_col_reg, pen_col_next;
    logic [COORD_W-1:0]   pen_row_reg, pen_row_next;
    logic [COORD_W-1:0]   col_low_reg, col_low_next;
    logic [COORD_W-1:0]   col_high_reg, col_high_next;
    logic [COORD_W-1:0]   row_low_reg, row_low_next;
    logic [COORD_W-1:0]   row_high_reg, row_high_next;

    // Result register
    logic                 res_valid_reg, res_valid_next;
    logic [FIELD_W-1:0]   res_pen_col_reg, res_pen_col_next;
    logic [FIELD_W-1:0]   res_pen_row_reg, res_pen_row_next;
    logic [FIELD_W-1:0]   res_col_low_reg, res_col_low_next;
    logic [FIELD_W-1:0]   res_col_high_reg, res_col_high_next;
    logic [FIELD_W-1:0]   res_row_low_reg, res_row_low_next;
    logic [FIELD_W-1:0]   res_row_high_reg, res_row_high_next;
    logic [MARK_W-1:0]    res_mark_reg, res_mark_next;
    logic                 res_off_reg, res_off_next;

    // Memory port
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [MARK_W-1:0]    mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [MARK_W-1:0]    mem_rdata;

    logic                 accept;
    logic                 load_item;
    logic                 load_read;

    // Move decode
    logic                 is_code_act;
    logic                 is_code;
    logic [2:0]           dir;
    step_t                dc, dr;
    logic                 col_off, row_off;
    logic                 move_ok;
    logic [COORD_W-1:0]   new_col, new_row;
    mark_t                new_mark;
    logic                 rd_in_grid;

    // Hold new requests during a clearing pass or a pending read, and while
    // a finished result is still stalled.
    assign cmd_stall = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);
    assign accept    = cmd_valid && !cmd_stall;

    // ------------------------------------------------------------------
    // Decode a code byte into a one-cell step and check the grid edges
    // ------------------------------------------------------------------
    always_comb
    begin
        is_code_act = (action == ACT_CODE);
        is_code     = (code_byte >= CHAR_ZERO) && (code_byte <= CHAR_SEVEN);
        dir         = 3'(code_byte - CHAR_ZERO);
        dc          = col_step(dir);
        dr          = row_step(dir);
        new_mark    = dir_mark(dir);

        col_off = ((dc == STEP_INC) && (pen_col_reg == EDGE_MAX)) ||
                  ((dc == STEP_DEC) && (pen_col_reg == '0));
        row_off = ((dr == STEP_INC) && (pen_row_reg == EDGE_MAX)) ||
                  ((dr == STEP_DEC) && (pen_row_reg == '0));

        unique case (dc)
            STEP_INC: new_col = pen_col_reg + COORD_W'(1);
            STEP_DEC: new_col = pen_col_reg - COORD_W'(1);
            default:  new_col = pen_col_reg;
        endcase
        unique case (dr)
            STEP_INC: new_row = pen_row_reg + COORD_W'(1);
            STEP_DEC: new_row = pen_row_reg - COORD_W'(1);
            default:  new_row = pen_row_reg;
        endcase

        move_ok    = is_code_act && is_code && !col_off && !row_off;
        rd_in_grid = (32'(read_col) < 32'(GRID_SIZE)) && (32'(read_row) < 32'(GRID_SIZE));
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (action == ACT_NEW))
                begin
                    state_next = ST_CLEAR;
                end
                else if (accept && (action == ACT_READ))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Controls per state: memory port, clear counter, result loads
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = {new_row, new_col};
        mem_wdata     = new_mark;
        mem_re        = 1'b0;
        mem_raddr     = {COORD_W'(read_row), COORD_W'(read_col)};
        clr_addr_next = clr_addr_reg;
        load_item     = 1'b0;
        load_read     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Blank one entry a cycle
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = MARK_BLANK;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mem_we        = move_ok;
                    mem_re        = (action == ACT_READ);
                    load_item     = (action != ACT_READ);
                    clr_addr_next = '0;
                end
            end
            ST_READ:
            begin
                load_read = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pen and bounding box
    // ------------------------------------------------------------------
    always_comb
    begin
        pen_col_next    = pen_col_reg;
        pen_row_next    = pen_row_reg;
        col_low_next    = col_low_reg;
        col_high_next   = col_high_reg;
        row_low_next    = row_low_reg;
        row_high_next   = row_high_reg;
        rd_in_grid_next = rd_in_grid_reg;

        if (accept && (action == ACT_NEW))
        begin
            pen_col_next  = CENTER;
            pen_row_next  = CENTER;
            col_low_next  = CENTER;
            col_high_next = CENTER;
            row_low_next  = CENTER;
            row_high_next = CENTER;
        end
        else if (accept && move_ok)
        begin
            pen_col_next = new_col;
            pen_row_next = new_row;
            if (new_col < col_low_reg)
            begin
                col_low_next = new_col;
            end
            if (new_col > col_high_reg)
            begin
                col_high_next = new_col;
            end
            if (new_row < row_low_reg)
            begin
                row_low_next = new_row;
            end
            if (new_row > row_high_reg)
            begin
                row_high_next = new_row;
            end
        end

        if (accept)
        begin
            rd_in_grid_next = rd_in_grid;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on a finished request, drop when taken
    // ------------------------------------------------------------------
    always_comb
    begin
        res_valid_next    = res_valid_reg && res_stall;
        res_pen_col_next  = res_pen_col_reg;
        res_pen_row_next  = res_pen_row_reg;
        res_col_low_next  = res_col_low_reg;
        res_col_high_next = res_col_high_reg;
        res_row_low_next  = res_row_low_reg;
        res_row_high_next = res_row_high_reg;
        res_mark_next     = res_mark_reg;
        res_off_next      = res_off_reg;

        if (load_item || load_read)
        begin
            // Pen state does not move during a read, so next equals current
            res_valid_next    = 1'b1;
            res_pen_col_next  = FIELD_W'(pen_col_next);
            res_pen_row_next  = FIELD_W'(pen_row_next);
            res_col_low_next  = FIELD_W'(col_low_next);
            res_col_high_next = FIELD_W'(col_high_next);
            res_row_low_next  = FIELD_W'(row_low_next);
            res_row_high_next = FIELD_W'(row_high_next);
        end

        if (load_item)
        begin
            res_mark_next = move_ok ? MARK_W'(new_mark) : MARK_W'(MARK_BLANK);
            res_off_next  = is_code_act && is_code && (col_off || row_off);
        end
        else if (load_read)
        begin
            res_mark_next = rd_in_grid_reg ? mem_rdata : MARK_W'(MARK_BLANK);
            res_off_next  = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
            pen_col_reg   <= CENTER;
            pen_row_reg   <= CENTER;
            col_low_reg   <= CENTER;
            col_high_reg  <= CENTER;
            row_low_reg   <= CENTER;
            row_high_reg  <= CENTER;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            res_valid_reg <= res_valid_next;
            pen_col_reg   <= pen_col_next;
            pen_row_reg   <= pen_row_next;
            col_low_reg   <= col_low_next;
            col_high_reg  <= col_high_next;
            row_low_reg   <= row_low_next;
            row_high_reg  <= row_high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_in_grid_reg   <= rd_in_grid_next;
        res_pen_col_reg  <= res_pen_col_next;
        res_pen_row_reg  <= res_pen_row_next;
        res_col_low_reg  <= res_col_low_next;
        res_col_high_reg <= res_col_high_next;
        res_row_low_reg  <= res_row_low_next;
        res_row_high_reg <= res_row_high_next;
        res_mark_reg     <= res_mark_next;
        res_off_reg      <= res_off_next;
    end

    // ------------------------------------------------------------------
    // Mark memory, addressed {row, col}
    // ------------------------------------------------------------------
    cclp_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MEM_DEPTH)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign res_valid    = res_valid_reg;
    assign pen_col      = res_pen_col_reg;
    assign pen_row      = res_pen_row_reg;
    assign box_col_low  = res_col_low_reg;
    assign box_col_high = res_col_high_reg;
    assign box_row_low  = res_row_low_reg;
    assign box_row_high = res_row_high_reg;
    assign cell_mark    = res_mark_reg;
    assign off_grid     = res_off_reg;

endmodule

// ===== rtl/core/cclp_ram.sv =====
`timescale 1ns / 1ps

module cclp_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/cclp_props.sv =====
`timescale 1ns / 1ps
`include "chain_code_line_plotter_core_assert.svh"

module cclp_props
    import cclp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic                res_valid,
    input  logic                res_stall,
    input  logic [FIELD_W-1:0]  pen_col,
    input  logic [FIELD_W-1:0]  pen_row,
    input  logic [FIELD_W-1:0]  box_col_low,
    input  logic [FIELD_W-1:0]  box_col_high,
    input  logic [FIELD_W-1:0]  box_row_low,
    input  logic [FIELD_W-1:0]  box_row_high,
    input  logic [MARK_W-1:0]   cell_mark,
    input  logic                off_grid
);

    // A stalled result holds its payload
    `CCLP_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(pen_col) && $stable(pen_row) && $stable(cell_mark)
        && $stable(off_grid), "stalled result changed")

    // A dropped move never reports a mark
    `CCLP_ASSERT_NOW(a_off_blank, res_valid && off_grid, cell_mark == MARK_BLANK,
        "off-grid result carries a mark")

    // The pen always lies inside the bounding box
    `CCLP_ASSERT_NOW(a_pen_in_box, res_valid,
        (box_col_low <= pen_col) && (pen_col <= box_col_high)
        && (box_row_low <= pen_row) && (pen_row <= box_row_high),
        "pen outside bounding box")

    // A new path starts the clearing pass, which holds off the next request
    `CCLP_ASSERT_NEXT(a_new_clears, cmd_valid && !cmd_stall && (action == ACT_NEW),
        cmd_stall, "no clearing pass after new path")

endmodule

bind chain_code_line_plotter_core cclp_props u_cclp_props (.*);

// ===== dv/chain_code_line_plotter_core_test.sv =====
`timescale 1ns / 1ps

module chain_code_line_plotter_core_test;
    import cclp_pkg::*;

    // Action code 3 is outside the enum; the block returns a result but changes nothing
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    // Pen step and line mark by chain code direction, rows growing downward
    localparam int    COL_DELTA  [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    localparam int    ROW_DELTA  [8] = '{0, -1, -1, -1, 0, 1, 1, 1};
    localparam mark_t TRACE_MARK [8] = '{MARK_DASH, MARK_SLASH, MARK_BAR, MARK_BACK,
                                         MARK_DASH, MARK_SLASH, MARK_BAR, MARK_BACK};

    typedef struct {
        logic [FIELD_W-1:0] pen_col;
        logic [FIELD_W-1:0] pen_row;
        logic [FIELD_W-1:0] col_low;
        logic [FIELD_W-1:0] col_high;
        logic [FIELD_W-1:0] row_low;
        logic [FIELD_W-1:0] row_high;
        logic [MARK_W-1:0]  mark;
        logic               off_grid;
    } plot_result_t;

    // Tracks the raster, the pen and the box, and holds the results still owed
    class plot_scoreboard;
        mark_t        raster [GRID_SIZE * GRID_SIZE];
        int           pen_c;
        int           pen_r;
        int           col_lo;
        int           col_hi;
        int           row_lo;
        int           row_hi;
        plot_result_t owed_q [$];
        int           failures;

        function new();
            failures = 0;
            restart_path();
        endfunction

        function void restart_path();
            foreach (raster[i])
                raster[i] = MARK_BLANK;
            pen_c  = GRID_SIZE / 2;
            pen_r  = GRID_SIZE / 2;
            col_lo = GRID_SIZE / 2;
            col_hi = GRID_SIZE / 2;
            row_lo = GRID_SIZE / 2;
            row_hi = GRID_SIZE / 2;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] code_in,
                                   logic [FIELD_W-1:0] col, logic [FIELD_W-1:0] row);
            plot_result_t want;
            mark_t        mark;
            logic         flag;
            int           dir;
            int           nc;
            int           nr;

            mark = MARK_BLANK;
            flag = 1'b0;
            case (act)
                ACT_CODE:
                begin
                    if (code_in >= CHAR_ZERO && code_in <= CHAR_SEVEN)
                    begin
                        dir = int'(code_in - CHAR_ZERO);
                        nc  = pen_c + COL_DELTA[dir];
                        nr  = pen_r + ROW_DELTA[dir];
                        if (nc < 0 || nc >= GRID_SIZE || nr < 0 || nr >= GRID_SIZE)
                            flag = 1'b1;
                        else
                        begin
                            pen_c = nc;
                            pen_r = nr;
                            raster[nr * GRID_SIZE + nc] = TRACE_MARK[dir];
                            mark = TRACE_MARK[dir];
                            if (nc < col_lo) col_lo = nc;
                            if (nc > col_hi) col_hi = nc;
                            if (nr < row_lo) row_lo = nr;
                            if (nr > row_hi) row_hi = nr;
                        end
                    end
                end
                ACT_NEW:
                    restart_path();
                ACT_READ:
                begin
                    if (int'(col) < GRID_SIZE && int'(row) < GRID_SIZE)
                        mark = raster[int'(row) * GRID_SIZE + int'(col)];
                end
                default:
                    ;
            endcase

            want.pen_col  = FIELD_W'(pen_c);
            want.pen_row  = FIELD_W'(pen_r);
            want.col_low  = FIELD_W'(col_lo);
            want.col_high = FIELD_W'(col_hi);
            want.row_low  = FIELD_W'(row_lo);
            want.row_high = FIELD_W'(row_hi);
            want.mark     = mark;
            want.off_grid = flag;
            owed_q.push_back(want);
        endfunction

        // Compare one accepted result against the oldest one owed
        function void check_result(plot_result_t got);
            plot_result_t want;
            int           want_v [8];
            int           got_v  [8];
            string        names  [8];
            bit           bad;

            names = '{"pen_col", "pen_row", "box_col_low", "box_col_high",
                      "box_row_low", "box_row_high", "cell_mark", "off_grid"};
            if (owed_q.size() == 0)
            begin
                $display("%0t ns: result with no request waiting", $time);
                failures++;
                return;
            end
            want   = owed_q.pop_front();
            want_v = '{want.pen_col, want.pen_row, want.col_low, want.col_high,
                       want.row_low, want.row_high, want.mark, want.off_grid};
            got_v  = '{got.pen_col, got.pen_row, got.col_low, got.col_high,
                       got.row_low, got.row_high, got.mark, got.off_grid};
            bad = 1'b0;
            foreach (want_v[i])
            begin
                if (want_v[i] !== got_v[i])
                begin
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, names[i], want_v[i], got_v[i]);
                    bad = 1'b1;
                end
            end
            if (bad)
                failures++;
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]  code_byte;
    logic [FIELD_W-1:0] read_col;
    logic [FIELD_W-1:0] read_row;
    logic               res_valid;
    logic               res_stall;
    logic [FIELD_W-1:0] pen_col;
    logic [FIELD_W-1:0] pen_row;
    logic [FIELD_W-1:0] box_col_low;
    logic [FIELD_W-1:0] box_col_high;
    logic [FIELD_W-1:0] box_row_low;
    logic [FIELD_W-1:0] box_row_high;
    logic [MARK_W-1:0]  cell_mark;
    logic               off_grid;

    plot_scoreboard board;
    bit             allow_idle;
    int             requests_sent;

    chain_code_line_plotter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .action       (action),
        .code_byte    (code_byte),
        .read_col     (read_col),
        .read_row     (read_row),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .pen_col      (pen_col),
        .pen_row      (pen_row),
        .box_col_low  (box_col_low),
        .box_col_high (box_col_high),
        .box_row_low  (box_row_low),
        .box_row_high (box_row_high),
        .cell_mark    (cell_mark),
        .off_grid     (off_grid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Drive one request at the falling edge, hold it until accepted
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] code_in,
                                input logic [FIELD_W-1:0] col, input logic [FIELD_W-1:0] row);
        @(negedge clk);
        if (allow_idle && $urandom_range(0, 4) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        action    <= act;
        code_byte <= code_in;
        read_col  <= col;
        read_row  <= row;
        do
            @(posedge clk);
        while (cmd_stall);
        board.note_request(act, code_in, col, row);
        requests_sent++;
    endtask

    // Drop valid and hold off until every owed result has come back or max_cycles pass
    task automatic drain_results(input int max_cycles);
        int waited;

        @(negedge clk);
        cmd_valid <= 1'b0;
        waited = 0;
        while (board.pending() != 0 && waited < max_cycles)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Receiver side: stall in random bursts while idling is allowed
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (allow_idle && $urandom_range(0, 6) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Sample results at the rising edge
    always @(posedge clk)
    begin : result_monitor
        plot_result_t seen;

        if (rst_n && res_valid && !res_stall)
        begin
            seen.pen_col  = pen_col;
            seen.pen_row  = pen_row;
            seen.col_low  = box_col_low;
            seen.col_high = box_col_high;
            seen.row_low  = box_row_low;
            seen.row_high = box_row_high;
            seen.mark     = cell_mark;
            seen.off_grid = off_grid;
            board.check_result(seen);
        end
    end

    // Each new path costs a full clearing pass; this bound covers many of them
    initial
    begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int pick;
        int dir;
        int run_len;
        int paths_left;

        cmd_valid     = 1'b0;
        action        = ACT_CODE;
        code_byte     = '0;
        read_col      = '0;
        read_row      = '0;
        rst_n         = 1'b0;
        allow_idle    = 1'b1;
        requests_sent = 0;
        board         = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: blank raster corners and centre
        send_request(ACT_READ, 8'h00, 7'd0, 7'd0);
        send_request(ACT_READ, 8'hFF, 7'd127, 7'd127);
        send_request(ACT_READ, 8'h00, 7'd64, 7'd64);
        // Walk every direction once; the loop closes back on the centre
        for (int d = 0; d < 8; d++)
            send_request(ACT_CODE, CHAR_ZERO + BYTE_W'(d), 7'd0, 7'd0);
        send_request(ACT_READ, 8'h00, 7'd65, 7'd64);
        send_request(ACT_READ, 8'h00, 7'd64, 7'd64);
        // Bytes just outside the code range and the byte extremes
        send_request(ACT_CODE, CHAR_ZERO - 8'd1, 7'd127, 7'd127);
        send_request(ACT_CODE, CHAR_SEVEN + 8'd1, 7'd0, 7'd0);
        send_request(ACT_CODE, 8'h00, 7'd0, 7'd0);
        send_request(ACT_CODE, 8'hFF, 7'd127, 7'd127);
        send_request(ACT_IGNORED, CHAR_ZERO, 7'd0, 7'd0);
        // New path after everything is back; the old trace must be gone
        drain_results(50000);
        send_request(ACT_NEW, 8'h00, 7'd0, 7'd0);
        send_request(ACT_READ, 8'h00, 7'd65, 7'd64);
        send_request(ACT_READ, 8'h00, 7'd127, 7'd0);

        // Random: straight runs reach the grid edges, reads follow the pen
        paths_left = 14;
        while (requests_sent < 820)
        begin
            allow_idle = (requests_sent < 700) && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                dir     = $urandom_range(0, 7);
                run_len = ($urandom_range(0, 6) == 0) ? $urandom_range(64, 90)
                                                      : $urandom_range(1, 10);
                repeat (run_len)
                begin
                    if ($urandom_range(0, 7) == 0)
                        dir = $urandom_range(0, 7);
                    send_request(ACT_CODE, CHAR_ZERO + BYTE_W'(dir),
                                 FIELD_W'($urandom_range(0, 127)),
                                 FIELD_W'($urandom_range(0, 127)));
                end
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                        send_request(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                                     FIELD_W'(board.pen_c + int'($urandom_range(0, 4)) - 2),
                                     FIELD_W'(board.pen_r + int'($urandom_range(0, 4)) - 2));
                    else
                        send_request(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                                     FIELD_W'($urandom_range(0, 127)),
                                     FIELD_W'($urandom_range(0, 127)));
                end
            end
            else if (pick < 96)
            begin
                repeat ($urandom_range(1, 3))
                    send_request(($urandom_range(0, 1) == 0) ? ACT_CODE : ACT_IGNORED,
                                 BYTE_W'($urandom_range(0, 255)),
                                 FIELD_W'($urandom_range(0, 127)),
                                 FIELD_W'($urandom_range(0, 127)));
            end
            else if (paths_left > 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    drain_results(50000);
                send_request(ACT_NEW, BYTE_W'($urandom_range(0, 255)),
                             FIELD_W'($urandom_range(0, 127)),
                             FIELD_W'($urandom_range(0, 127)));
                paths_left--;
            end
        end

        allow_idle = 1'b0;
        drain_results(50000);
        repeat (20) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, board.pending());
            board.failures++;
        end
        if (board.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
